[rtl/ngga_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the GGA field extractor.
// No dependencies; imported by every module of the block.
package ngga_pkg;

  localparam logic [7:0]  CH_COMMA    = 8'h2C;
  localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
  localparam logic [2:0]  HEADER_LEN  = 3'd6;
  localparam logic [2:0]  HEADER_SAT  = 3'd7;
  localparam logic [47:0] HEADER_RST  = 48'h244750474741;
  localparam int          CFG_AW      = 4;
  localparam logic [CFG_AW-1:0] ADDR_HEADER = 4'h0;

  typedef struct packed {
    logic [2:0] field_index;
    logic [7:0] char_value;
    logic [3:0] char_pos;
    logic       field_end;
    logic       sentence_done;
    logic       aborted;
  } ngga_result_t;

endpackage

[rtl/ngga_parser.sv]
`timescale 1ns / 1ps
// Line parser: header match, field walk and result formation for one byte.
// Depends on ngga_pkg.
module ngga_parser #(
  parameter int MAX_FIELD_CHARS = 16,
  parameter int FIELD_COUNT     = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            byte_value,
  input  logic [47:0]           header_pattern,
  output logic                  res_valid,
  output ngga_pkg::ngga_result_t res
);
  import ngga_pkg::*;

  localparam int FW        = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;
  localparam int POS_LIMIT = ((MAX_FIELD_CHARS - 1) < 15) ? (MAX_FIELD_CHARS - 1) : 15;

  typedef enum logic [1:0] {PH_HEADER, PH_FIELDS, PH_SKIP} phase_t;

  phase_t          phase_r, phase_nxt;
  logic [2:0]      hcount_r, hcount_nxt;
  logic            hequal_r, hequal_nxt;
  logic [FW-1:0]   field_r, field_nxt;
  logic [3:0]      pos_r, pos_nxt;

  logic [2:0]      hidx;
  logic [7:0]      want;
  logic [3:0]      field_ext;
  logic            last;
  logic            is_nl;
  logic            is_comma;

  assign hidx      = HEADER_LEN - 3'd1 - hcount_r;
  assign want      = header_pattern[{hidx, 3'b000} +: 8];
  assign field_ext = 4'(field_r);
  assign last      = (int'(field_r) == FIELD_COUNT - 1);
  assign is_nl     = (byte_value == CH_NEWLINE);
  assign is_comma  = (byte_value == CH_COMMA);

  always_comb begin
    phase_nxt  = phase_r;
    hcount_nxt = hcount_r;
    hequal_nxt = hequal_r;
    field_nxt  = field_r;
    pos_nxt    = pos_r;
    res_valid  = 1'b0;
    res.field_index   = field_ext[2:0];
    res.char_value    = 8'd0;
    res.char_pos      = pos_r;
    res.field_end     = 1'b0;
    res.sentence_done = 1'b0;
    res.aborted       = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        if (is_nl) begin
          hcount_nxt = 3'd0;
          hequal_nxt = 1'b1;
          field_nxt  = '0;
          pos_nxt    = 4'd0;
        end else if (is_comma) begin
          if (hequal_r && hcount_r == HEADER_LEN) begin
            phase_nxt = PH_FIELDS;
            field_nxt = '0;
            pos_nxt   = 4'd0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end else begin
          if (hcount_r >= HEADER_LEN || want != byte_value) begin
            hequal_nxt = 1'b0;
          end
          if (hcount_r < HEADER_SAT) begin
            hcount_nxt = hcount_r + 3'd1;
          end
        end
      end
      PH_FIELDS: begin
        res_valid = 1'b1;
        if (is_nl) begin
          res.aborted = 1'b1;
          phase_nxt   = PH_HEADER;
          hcount_nxt  = 3'd0;
          hequal_nxt  = 1'b1;
          field_nxt   = '0;
          pos_nxt     = 4'd0;
        end else if (is_comma) begin
          res.field_end     = 1'b1;
          res.sentence_done = last;
          if (last) begin
            phase_nxt = PH_SKIP;
          end else begin
            field_nxt = field_r + FW'(1);
          end
          pos_nxt = 4'd0;
        end else begin
          res.char_value = byte_value;
          if (pos_r < 4'(POS_LIMIT)) begin
            pos_nxt = pos_r + 4'd1;
          end
        end
      end
      default: begin
        if (is_nl) begin
          phase_nxt  = PH_HEADER;
          hcount_nxt = 3'd0;
          hequal_nxt = 1'b1;
          field_nxt  = '0;
          pos_nxt    = 4'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hcount_r <= 3'd0;
      hequal_r <= 1'b1;
      field_r  <= '0;
      pos_r    <= 4'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      hequal_r <= hequal_nxt;
      field_r  <= field_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

[rtl/ngga_out_buf.sv]
`timescale 1ns / 1ps
// Result register with a skid stage between the parser and the output channel.
// Depends on ngga_pkg.
module ngga_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ngga_pkg::ngga_result_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ngga_pkg::ngga_result_t out_data,
  output logic                   skid_full
);
  import ngga_pkg::*;

  logic         out_valid_r;
  logic         skid_valid_r;
  ngga_result_t out_data_r;
  ngga_result_t skid_data_r;

  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign skid_full = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

[rtl/nmea_gga_field_extractor_unit.sv]
`timescale 1ns / 1ps
// Top level of the GGA field extractor: header register, parser, result buffer.
// Depends on ngga_pkg, ngga_parser and ngga_out_buf.
//
// Usage:
//   Feed received bytes on in_byte_value with in_valid/in_ready. Each accepted
//   byte updates the line parser in the same cycle; a byte inside the
//   FIELD_COUNT fields (five by default) after a matching header gives one
//   result item on the out_ channel, other bytes give none.
//   Each result is registered in the output register or the skid stage.
//   Throughput: one byte per cycle while in_ready is high.
//   A two-entry result buffer (output register plus skid stage) lets the
//   block keep taking bytes while one result waits; in_ready drops only when
//   both entries are full because out_ready stayed low.
//   The header pattern is written over the APB port at address 0 (64-bit
//   data, low 48 bits used, first character in bits 47:40); it reads back
//   there. Write it only while the block is idle.
//   Reset (synchronous, rst_n low) empties the buffer, starts a new line and
//   loads the pattern "$GPGGA".
module nmea_gga_field_extractor_unit #(
  parameter int MAX_FIELD_CHARS = 16,
  parameter int FIELD_COUNT     = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_field_index,
  output logic [7:0]                  out_char_value,
  output logic [3:0]                  out_char_pos,
  output logic                        out_field_end,
  output logic                        out_sentence_done,
  output logic                        out_aborted,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ngga_pkg::CFG_AW-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import ngga_pkg::*;

  logic [47:0]  header_r;
  logic         accept;
  logic         res_valid;
  ngga_result_t res;
  ngga_result_t out_data;
  logic         space;
  logic         skid_full;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_HEADER) ? {16'd0, header_r} : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_HEADER) begin
      header_r <= pwdata[47:0];
    end
  end

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  ngga_parser #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
    .FIELD_COUNT     (FIELD_COUNT)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .byte_value     (in_byte_value),
    .header_pattern (header_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  ngga_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

  assign out_field_index   = out_data.field_index;
  assign out_char_value    = out_data.char_value;
  assign out_char_pos      = out_data.char_pos;
  assign out_field_end     = out_data.field_end;
  assign out_sentence_done = out_data.sentence_done;
  assign out_aborted       = out_data.aborted;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full |-> out_valid)
    else $error("skid entry held while output register empty");

  a_end_abort_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_field_end && out_aborted))
    else $error("result marks both field end and abort");

  a_done_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sentence_done) |-> out_field_end)
    else $error("sentence done without field end");

  a_marker_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_field_end || out_aborted)) |-> (out_char_value == 8'd0))
    else $error("marker result carries a character");
`endif

endmodule
